// File: rtl/core/peer_stream_deframer_top_macros.svh
// Assertion macros shared by the peer stream deframer RTL.
// Depends on nothing; the asserting module must have aclk and aresetn in scope.
`ifndef PEER_STREAM_DEFRAMER_TOP_MACROS_SVH
`define PEER_STREAM_DEFRAMER_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PSD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PSD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// File: rtl/core/psd_pkg.sv
// Package for the peer stream deframer: result and config types, codes, constants.
// Used by psd_cfg_regs, psd_engine and peer_stream_deframer_top; depends on nothing.
package psd_pkg;

    localparam int unsigned HELLO_HDR_BYTES = 6;
    localparam int unsigned CHUNK_HDR_BYTES = 4;
    localparam int unsigned APB_ADDR_W      = 5;

    // Result kinds.
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_ID       = 3'd1;
    localparam logic [2:0] KIND_LABEL    = 3'd2;
    localparam logic [2:0] KIND_PROVIDER = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd4;
    localparam logic [2:0] KIND_EMPTY    = 3'd5;
    localparam logic [2:0] KIND_ERROR    = 3'd6;
    localparam logic [2:0] KIND_HALTED   = 3'd7;

    // Error codes.
    localparam logic [1:0] ERR_BAD_TYPE     = 2'd0;
    localparam logic [1:0] ERR_NO_HELLO     = 2'd1;
    localparam logic [1:0] ERR_NAME_LEN     = 2'd2;
    localparam logic [1:0] ERR_CHUNK_LEN    = 2'd3;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_HELLO_TYPE  = 3'd0;
    localparam logic [2:0] REG_CHUNK_TYPE  = 3'd1;
    localparam logic [2:0] REG_NAME_LIMIT  = 3'd2;
    localparam logic [2:0] REG_CHUNK_LIMIT = 3'd3;
    localparam logic [2:0] REG_PEER_SLOT   = 3'd4;

    typedef struct packed {
        logic [7:0]  hello_type_code;
        logic [7:0]  chunk_type_code;
        logic [15:0] name_length_limit;
        logic [31:0] chunk_length_limit;
        logic [15:0] peer_slot;
    } psd_cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_out;
        logic        last;
        logic [15:0] slot;
        logic [1:0]  error_code;
    } psd_result_t;

endpackage

// File: rtl/core/psd_cfg_regs.sv
// APB configuration registers of the peer stream deframer.
// Depends on psd_pkg.
module psd_cfg_regs
    import psd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output psd_cfg_t              cfg
);

    psd_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hello_type_code    <= 8'd1;
            cfg_reg.chunk_type_code    <= 8'd2;
            cfg_reg.name_length_limit  <= 16'd256;
            cfg_reg.chunk_length_limit <= 32'd65536;
            cfg_reg.peer_slot          <= 16'd0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HELLO_TYPE:  cfg_reg.hello_type_code    <= pwdata[7:0];
                REG_CHUNK_TYPE:  cfg_reg.chunk_type_code    <= pwdata[7:0];
                REG_NAME_LIMIT:  cfg_reg.name_length_limit  <= pwdata[15:0];
                REG_CHUNK_LIMIT: cfg_reg.chunk_length_limit <= pwdata;
                REG_PEER_SLOT:   cfg_reg.peer_slot          <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HELLO_TYPE:  prdata = {24'd0, cfg_reg.hello_type_code};
            REG_CHUNK_TYPE:  prdata = {24'd0, cfg_reg.chunk_type_code};
            REG_NAME_LIMIT:  prdata = {16'd0, cfg_reg.name_length_limit};
            REG_CHUNK_LIMIT: prdata = cfg_reg.chunk_length_limit;
            REG_PEER_SLOT:   prdata = {16'd0, cfg_reg.peer_slot};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/core/psd_engine.sv
// Deframing state machine: consumes one byte per step and forms one result.
// Depends on psd_pkg and peer_stream_deframer_top_macros.svh.
`include "peer_stream_deframer_top_macros.svh"

module psd_engine
    import psd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  psd_cfg_t    cfg,
    output psd_result_t res
);

    localparam logic [2:0] PH_TYPE      = 3'd0;
    localparam logic [2:0] PH_HELLO_HDR = 3'd1;
    localparam logic [2:0] PH_STRINGS   = 3'd2;
    localparam logic [2:0] PH_CHUNK_HDR = 3'd3;
    localparam logic [2:0] PH_PAYLOAD   = 3'd4;

    localparam logic [3:0] HELLO_HDR_N = 4'(HELLO_HDR_BYTES);
    localparam logic [3:0] CHUNK_HDR_N = 4'(CHUNK_HDR_BYTES);

    logic [2:0]  phase_reg,           phase_next;
    logic [2:0]  header_count_reg,    header_count_next;
    logic [39:0] header_shift_reg,    header_shift_next;
    logic [15:0] id_length_reg,       id_length_next;
    logic [15:0] label_length_reg,    label_length_next;
    logic [17:0] string_position_reg, string_position_next;
    logic [31:0] bytes_remaining_reg, bytes_remaining_next;
    logic        hello_seen_reg,      hello_seen_next;
    logic        halted_reg,          halted_next;
    logic [1:0]  halt_code_reg,       halt_code_next;

    logic [3:0]  count_inc;
    logic [15:0] idl, lbl, prl;
    logic [31:0] chunk_len;
    logic [16:0] id_label_sum;
    logic        name_bad;

    assign count_inc    = {1'b0, header_count_reg} + 4'd1;
    assign idl          = header_shift_reg[39:24];
    assign lbl          = header_shift_reg[23:8];
    assign prl          = {header_shift_reg[7:0], rx_byte};
    assign chunk_len    = {header_shift_reg[23:0], rx_byte};
    assign id_label_sum = {1'b0, id_length_reg} + {1'b0, label_length_reg};
    assign name_bad     = (idl == 16'd0) || (idl >= cfg.name_length_limit) ||
                          (lbl >= cfg.name_length_limit) || (prl >= cfg.name_length_limit);

    always_comb begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        header_shift_next    = header_shift_reg;
        id_length_next       = id_length_reg;
        label_length_next    = label_length_reg;
        string_position_next = string_position_reg;
        bytes_remaining_next = bytes_remaining_reg;
        hello_seen_next      = hello_seen_reg;
        halted_next          = halted_reg;
        halt_code_next       = halt_code_reg;

        res.kind       = KIND_HEADER;
        res.data_out   = 8'd0;
        res.last       = 1'b0;
        res.slot       = cfg.peer_slot;
        res.error_code = 2'd0;

        if (halted_reg) begin
            res.kind       = KIND_HALTED;
            res.error_code = halt_code_reg;
        end else begin
            case (phase_reg)
                PH_HELLO_HDR: begin
                    if (count_inc < HELLO_HDR_N) begin
                        header_shift_next = {header_shift_reg[31:0], rx_byte};
                        header_count_next = count_inc[2:0];
                    end else begin
                        header_count_next = 3'd0;
                        header_shift_next = 40'd0;
                        if (name_bad) begin
                            halted_next    = 1'b1;
                            halt_code_next = ERR_NAME_LEN;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NAME_LEN;
                        end else begin
                            id_length_next       = idl;
                            label_length_next    = lbl;
                            string_position_next = 18'd0;
                            bytes_remaining_next = {16'd0, idl} + {16'd0, lbl} + {16'd0, prl};
                            phase_next           = PH_STRINGS;
                        end
                    end
                end
                PH_STRINGS: begin
                    if (string_position_reg < {2'd0, id_length_reg}) begin
                        res.kind = KIND_ID;
                    end else if (string_position_reg < {1'b0, id_label_sum}) begin
                        res.kind = KIND_LABEL;
                    end else begin
                        res.kind = KIND_PROVIDER;
                    end
                    res.data_out         = rx_byte;
                    string_position_next = string_position_reg + 18'd1;
                    if (bytes_remaining_reg <= 32'd1) begin
                        bytes_remaining_next = 32'd0;
                        hello_seen_next      = 1'b1;
                        phase_next           = PH_TYPE;
                        res.last             = 1'b1;
                    end else begin
                        bytes_remaining_next = bytes_remaining_reg - 32'd1;
                    end
                end
                PH_CHUNK_HDR: begin
                    if (count_inc < CHUNK_HDR_N) begin
                        header_shift_next = {header_shift_reg[31:0], rx_byte};
                        header_count_next = count_inc[2:0];
                    end else begin
                        header_count_next = 3'd0;
                        header_shift_next = 40'd0;
                        if (chunk_len > cfg.chunk_length_limit) begin
                            halted_next    = 1'b1;
                            halt_code_next = ERR_CHUNK_LEN;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_CHUNK_LEN;
                        end else if (chunk_len == 32'd0) begin
                            phase_next = PH_TYPE;
                            res.kind   = KIND_EMPTY;
                            res.last   = 1'b1;
                        end else begin
                            bytes_remaining_next = chunk_len;
                            phase_next           = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res.kind     = KIND_PAYLOAD;
                    res.data_out = rx_byte;
                    if (bytes_remaining_reg <= 32'd1) begin
                        bytes_remaining_next = 32'd0;
                        phase_next           = PH_TYPE;
                        res.last             = 1'b1;
                    end else begin
                        bytes_remaining_next = bytes_remaining_reg - 32'd1;
                    end
                end
                default: begin
                    // A type byte; the hello code wins when both codes match.
                    if (rx_byte == cfg.hello_type_code) begin
                        phase_next        = PH_HELLO_HDR;
                        header_count_next = 3'd0;
                        header_shift_next = 40'd0;
                    end else if (rx_byte == cfg.chunk_type_code && hello_seen_reg) begin
                        phase_next        = PH_CHUNK_HDR;
                        header_count_next = 3'd0;
                        header_shift_next = 40'd0;
                    end else if (rx_byte == cfg.chunk_type_code) begin
                        halted_next    = 1'b1;
                        halt_code_next = ERR_NO_HELLO;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_NO_HELLO;
                    end else begin
                        halted_next    = 1'b1;
                        halt_code_next = ERR_BAD_TYPE;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BAD_TYPE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_TYPE;
            header_count_reg    <= 3'd0;
            bytes_remaining_reg <= 32'd0;
            hello_seen_reg      <= 1'b0;
            halted_reg          <= 1'b0;
            halt_code_reg       <= 2'd0;
        end else if (step) begin
            phase_reg           <= phase_next;
            header_count_reg    <= header_count_next;
            bytes_remaining_reg <= bytes_remaining_next;
            hello_seen_reg      <= hello_seen_next;
            halted_reg          <= halted_next;
            halt_code_reg       <= halt_code_next;
        end
    end

    // Header and string bookkeeping is only read after being loaded.
    always_ff @(posedge aclk) begin
        if (step) begin
            header_shift_reg    <= header_shift_next;
            id_length_reg       <= id_length_next;
            label_length_reg    <= label_length_next;
            string_position_reg <= string_position_next;
        end
    end

    `PSD_ASSERT_CLK(a_halt_sticky, halted_reg |=> halted_reg, "halt flag cleared without reset")
    `PSD_ASSERT_CLK(a_hello_sticky, hello_seen_reg |=> hello_seen_reg, "hello flag cleared")
    `PSD_ASSERT_CLK(a_halted_result, step && halted_reg |-> res.kind == KIND_HALTED && res.error_code == halt_code_reg, "halted block gave a live result")
    `PSD_ASSERT_NEVER(a_stream_count, (phase_reg == PH_STRINGS || phase_reg == PH_PAYLOAD) && bytes_remaining_reg == 32'd0, "streaming phase with no bytes left")

endmodule

// File: rtl/core/peer_stream_deframer_top.sv
// Peer stream deframer: one received byte in, one tagged result item out.
// An accepted item is held in the input register, processed, then held in the result register.
// Throughput: one item per cycle; the input register and result register stall only on m_ready.
// Reset: synchronous, active-low aresetn clears the pipeline, frame state and halt flag,
// and loads the configuration registers with their defaults. Depends on psd_pkg.
module peer_stream_deframer_top
    import psd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_kind,
    output logic [7:0]            m_data_out,
    output logic                  m_last,
    output logic [15:0]           m_slot,
    output logic [1:0]            m_error_code,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    psd_cfg_t    cfg;
    psd_result_t res;
    psd_result_t out_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic        advance;

    // The configuration registers sit behind a plain APB slave with no wait states.
    psd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The held item moves into the result register whenever that register is
    // empty or is being drained in the same cycle. The deframing state advances
    // exactly on that move, so each item updates the state once.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // A new item is taken whenever the input register is empty or is moving on,
    // so a waiting result stops the next byte only while the input register is full.
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    psd_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Result register: loaded on advance, emptied when the sink takes the item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_reg.kind;
    assign m_data_out   = out_reg.data_out;
    assign m_last       = out_reg.last;
    assign m_slot       = out_reg.slot;
    assign m_error_code = out_reg.error_code;

endmodule
